// ----- sv/fnuc_pkg.sv -----
// Shared types and constants for the farthest-next-use cache.
package fnuc_pkg;
	localparam int AddrW = 48;
	localparam int UseW = 40;
	localparam int KeyW = 41;
	localparam int CntW = 16;
	localparam int CfgW = 7;

	typedef struct packed {
		logic [AddrW-1:0] tag;
		logic [KeyW-1:0]  key;
	} line_t;

	typedef struct packed {
		logic             valid;
		logic [KeyW-1:0]  key;
		logic [AddrW-1:0] tag;
		logic             dirty;
	} cand_t;
endpackage

// ----- sv/fnuc_cell.sv -----
// One cache line cell: tag match, update and one step of the victim scan chain.
module fnuc_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [fnuc_pkg::AddrW-1:0] probe_addr,
	input  logic [fnuc_pkg::AddrW-1:0] fill_addr,
	input  logic                   upd_en,
	input  logic                   fill_en,
	input  logic [fnuc_pkg::KeyW-1:0] new_key,
	input  logic                   new_wr,
	input  logic                   scan_load,
	input  fnuc_pkg::cand_t        scan_in,
	output fnuc_pkg::cand_t        scan_out,
	output logic                   match,
	output logic                   valid
);
	import fnuc_pkg::*;

	line_t line_q;
	logic  valid_q;
	logic  dirty_q;
	cand_t cand_q;
	cand_t mine;

	assign valid = valid_q;
	assign match = valid_q && (line_q.tag == probe_addr);

	always_comb begin
		mine.valid = valid_q;
		mine.key = line_q.key;
		mine.tag = line_q.tag;
		mine.dirty = dirty_q;
	end

	assign scan_out = cand_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
		end else if (fill_en) begin
			valid_q <= 1'b1;
			dirty_q <= new_wr;
		end else if (upd_en && new_wr) begin
			dirty_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fill_en) begin
			line_q.tag <= fill_addr;
		end
		if (fill_en || upd_en) begin
			line_q.key <= new_key;
		end
	end

	// scan: carry the leftmost maximum toward the top end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else if (scan_load) begin
			cand_q <= mine;
		end else if (scan_in.valid && (!cand_q.valid || scan_in.key >= cand_q.key)) begin
			cand_q <= scan_in;
		end
	end
endmodule

// ----- sv/farthest_next_use_cache.sv -----
// Top level of the farthest-next-use cache.
// One request per access on the in channel (in_valid/in_stall); one result on the out
// channel (out_valid/out_stall). Tag match is parallel across a row of line cells.
// A hit or a fill passes from the look-up state to the done state. A miss that must
// evict runs a victim scan along the cell chain: each cycle every cell hands its best
// candidate to the next cell, while a counter loaded with LINES, the chain length, runs down.
// One request is in flight at a time; in_stall is high while busy or while a result
// waits. The result register holds while out_stall is high.
// lines_in_use is written through cfg_we/cfg_data; reset value 64, 0 acts as 1, above
// LINES acts as LINES. Reset empties all lines and clears the miss tally.
module farthest_next_use_cache #(
	parameter int LINES = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [fnuc_pkg::CfgW-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [fnuc_pkg::AddrW-1:0] block_address,
	input  logic                       is_write,
	input  logic [fnuc_pkg::UseW-1:0]  next_use,
	input  logic                       never_again,
	input  logic                       end_of_request,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       hit,
	output logic                       evicted,
	output logic                       writeback,
	output logic [fnuc_pkg::AddrW-1:0] victim_block,
	output logic [fnuc_pkg::CntW-1:0]  request_misses
);
	import fnuc_pkg::*;

	localparam int IdxW = $clog2(LINES);
	localparam int FillW = $clog2(LINES + 1);
	localparam int ScanW = $clog2(LINES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]       state_q;
	logic [CfgW-1:0]  cfg_q;
	logic [FillW-1:0] fill_q;
	logic [CntW-1:0]  tally_q;
	logic [ScanW-1:0] scan_q;
	logic [AddrW-1:0] addr_q;
	logic             wr_q;
	logic             eor_q;
	logic [KeyW-1:0]  key_q;

	logic [LINES-1:0] match_v;
	logic [LINES-1:0] valid_v;
	logic [LINES-1:0] upd_v;
	logic [LINES-1:0] fill_v;
	cand_t            chain [LINES+1];
	logic             scan_load;
	logic [FillW-1:0] usable;
	logic             any_hit;
	logic [CntW-1:0]  tally_inc;
	logic             accept;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || out_valid;
	assign any_hit = |match_v;
	assign scan_load = (state_q == ST_LOOK);
	assign chain[0] = '0;
	assign tally_inc = (tally_q == {CntW{1'b1}}) ? tally_q : tally_q + 1'b1;

	always_comb begin
		if (cfg_q == '0) begin
			usable = FillW'(1);
		end else if ({{(32-CfgW){1'b0}}, cfg_q} > 32'(LINES)) begin
			usable = FillW'(LINES);
		end else begin
			usable = FillW'(cfg_q);
		end
	end

	// victim slot: the cell whose tag equals the scan winner and is valid
	cand_t win;
	assign win = chain[LINES];

	always_comb begin
		for (int i = 0; i < LINES; i++) begin
			upd_v[i] = (state_q == ST_LOOK) && match_v[i];
			fill_v[i] = 1'b0;
			if (state_q == ST_LOOK && !any_hit && fill_q < usable) begin
				fill_v[i] = (fill_q[IdxW-1:0] == IdxW'(i));
			end
		end
		if (state_q == ST_SCAN && scan_q == '0) begin
			for (int i = 0; i < LINES; i++) begin
				fill_v[i] = valid_v[i] && match_v[i];
			end
		end
	end

	// during the scan the probe bus carries the winner's tag so the victim cell matches
	logic [AddrW-1:0] probe;
	assign probe = (state_q == ST_SCAN && scan_q == '0) ? win.tag : addr_q;

	logic [AddrW-1:0] fill_tag;
	assign fill_tag = addr_q;

	for (genvar g = 0; g < LINES; g++) begin : g_cell
		fnuc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.probe_addr(probe),
			.fill_addr (fill_tag),
			.upd_en    (upd_v[g]),
			.fill_en   (fill_v[g]),
			.new_key   (key_q),
			.new_wr    (wr_q),
			.scan_load (scan_load),
			.scan_in   (chain[g]),
			.scan_out  (chain[g+1]),
			.match     (match_v[g]),
			.valid     (valid_v[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cfg_q <= CfgW'(64);
			fill_q <= '0;
			tally_q <= '0;
			scan_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					hit <= any_hit;
					evicted <= 1'b0;
					writeback <= 1'b0;
					victim_block <= '0;
					if (any_hit) begin
						request_misses <= tally_q;
						tally_q <= eor_q ? '0 : tally_q;
						state_q <= ST_DONE;
					end else begin
						request_misses <= tally_inc;
						tally_q <= eor_q ? '0 : tally_inc;
						if (fill_q < usable) begin
							fill_q <= fill_q + 1'b1;
							state_q <= ST_DONE;
						end else begin
							scan_q <= ScanW'(LINES);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_q == '0) begin
						evicted <= 1'b1;
						writeback <= win.dirty;
						victim_block <= win.tag;
						state_q <= ST_DONE;
					end else begin
						scan_q <= scan_q - 1'b1;
					end
				end
				ST_DONE: begin
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= block_address;
			wr_q <= is_write;
			eor_q <= end_of_request;
			key_q <= never_again ? {1'b1, {UseW{1'b0}}} : {1'b0, next_use};
		end
	end
endmodule

// ----- sim/fnuc_checker.sv -----
// Checker for the farthest-next-use cache: watches both channels, predicts and compares.
module fnuc_checker #(
	parameter int LINES = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [fnuc_pkg::CfgW-1:0]  cfg_data,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [fnuc_pkg::AddrW-1:0] block_address,
	input  logic                       is_write,
	input  logic [fnuc_pkg::UseW-1:0]  next_use,
	input  logic                       never_again,
	input  logic                       end_of_request,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       hit,
	input  logic                       evicted,
	input  logic                       writeback,
	input  logic [fnuc_pkg::AddrW-1:0] victim_block,
	input  logic [fnuc_pkg::CntW-1:0]  request_misses,
	output int                         fail_count,
	output int                         pending,
	output int                         hit_count,
	output int                         evict_count,
	output int                         writeback_count
);
	import fnuc_pkg::*;

	typedef struct packed {
		logic             hit;
		logic             evicted;
		logic             writeback;
		logic [AddrW-1:0] victim;
		logic [CntW-1:0]  misses;
	} access_result_t;

	logic [AddrW-1:0] tags [LINES];
	logic             valids [LINES];
	logic             dirties [LINES];
	logic [KeyW-1:0]  keys [LINES];
	int               filled;
	int               tally;
	int               limit_reg;
	access_result_t   expected_results [$];

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("error: %s got %0h expected %0h", what, got, want);
		fail_count++;
	endtask

	function automatic access_result_t predict_access();
		access_result_t r;
		int slot;
		int usable;
		bit found;
		logic [KeyW-1:0] best;
		logic [KeyW-1:0] key;
		r = '0;
		slot = -1;
		key = never_again ? {1'b1, {UseW{1'b0}}} : {1'b0, next_use};
		for (int i = 0; i < LINES; i++)
			if (slot < 0 && valids[i] && tags[i] == block_address) slot = i;
		if (slot >= 0) begin
			r.hit = 1'b1;
			keys[slot] = key;
			if (is_write) dirties[slot] = 1'b1;
		end else begin
			if (tally < 65535) tally++;
			usable = limit_reg == 0 ? 1 : (limit_reg > LINES ? LINES : limit_reg);
			if (filled < usable) begin
				slot = filled;
				filled++;
			end else begin
				found = 0;
				best = '0;
				slot = 0;
				for (int i = 0; i < LINES; i++)
					if (valids[i] && (!found || keys[i] > best)) begin
						found = 1;
						best = keys[i];
						slot = i;
					end
				if (found) begin
					r.evicted = 1'b1;
					r.writeback = dirties[slot];
					r.victim = tags[slot];
				end
			end
			tags[slot] = block_address;
			valids[slot] = 1'b1;
			dirties[slot] = is_write;
			keys[slot] = key;
		end
		r.misses = tally[CntW-1:0];
		if (end_of_request) tally = 0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		access_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < LINES; i++) begin
				valids[i] <= 1'b0;
				dirties[i] <= 1'b0;
			end
			filled = 0;
			tally = 0;
			limit_reg = 64;
			fail_count = 0;
			pending = 0;
			hit_count = 0;
			evict_count = 0;
			writeback_count = 0;
			expected_results.delete();
		end else begin
			if (cfg_we) limit_reg = cfg_data;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report("unexpected result", 0, 0);
				end else begin
					want = expected_results.pop_front();
					if (hit !== want.hit) report("hit", hit, want.hit);
					if (evicted !== want.evicted) report("evicted", evicted, want.evicted);
					if (writeback !== want.writeback)
						report("writeback", writeback, want.writeback);
					if (victim_block !== want.victim)
						report("victim_block", victim_block, want.victim);
					if (request_misses !== want.misses)
						report("request_misses", request_misses, want.misses);
					hit_count += want.hit;
					evict_count += want.evicted;
					writeback_count += want.writeback;
				end
			end
			if (in_valid && !in_stall) expected_results.push_back(predict_access());
			pending = expected_results.size();
		end
	end
endmodule

// ----- sim/tb_farthest_next_use_cache.sv -----
// Testbench top for the farthest-next-use cache: stimulus, idling and verdict.
module tb_farthest_next_use_cache;
	import fnuc_pkg::*;

	localparam int LINES = 64;
	localparam int CYCLE_LIMIT = 900000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CfgW-1:0]  cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic [AddrW-1:0] block_address;
	logic             is_write;
	logic [UseW-1:0]  next_use;
	logic             never_again;
	logic             end_of_request;
	logic             out_valid;
	logic             out_stall;
	logic             hit;
	logic             evicted;
	logic             writeback;
	logic [AddrW-1:0] victim_block;
	logic [CntW-1:0]  request_misses;
	int               fail_count;
	int               pending;
	int               hit_count;
	int               evict_count;
	int               writeback_count;
	int               cycles;
	int               sent;
	bit               hold_off;
	bit               sink_on;
	logic [AddrW-1:0] pool [16];

	farthest_next_use_cache #(.LINES(LINES)) dut (.*);
	fnuc_checker #(.LINES(LINES)) checker_i (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("farthest_next_use_cache: mismatch");
			$finish;
		end
	end

	// drain results with random stalls, and a long hold-off on request
	initial begin
		int gap;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			gap = sink_on ? $urandom_range(0, 4) : 0;
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap - 1) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send(input logic [AddrW-1:0] a, input bit w, input logic [UseW-1:0] u,
			input bit nv, input bit eor, input bit idle);
		int gap;
		gap = idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		block_address <= a;
		is_write <= w;
		next_use <= u;
		never_again <= nv;
		end_of_request <= eor;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic drain_and_write(input logic [CfgW-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LINES + 10) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int n, input int span);
		logic [AddrW-1:0] a;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: a = AddrW'({$urandom, $urandom});
				1: a = AddrW'({$urandom, $urandom}) & 48'h8000_0000_0001;
				default: a = pool[$urandom_range(0, span - 1)];
			endcase
			send(a, 1'($urandom_range(0, 1)), UseW'({$urandom, $urandom}),
				$urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0, 1'b1);
		end
	endtask

	initial begin
		int lim [6];
		lim = '{1, 0, 2, 3, 127, 64};
		sent = 0;
		hold_off = 0;
		sink_on = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		block_address = '0;
		is_write = 1'b0;
		next_use = '0;
		never_again = 1'b0;
		end_of_request = 1'b0;
		for (int i = 0; i < 16; i++) pool[i] = AddrW'({$urandom, $urandom});
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, fill, hits, eviction by rank and never-again
		drain_and_write(2);
		send('0, 1, '0, 0, 0, 0);
		send('1, 0, '1, 0, 0, 0);
		send('0, 0, 40'h5, 0, 0, 0);
		send(48'h1234, 0, 40'h9, 0, 0, 0);
		send(48'h5678, 1, 40'h3, 1, 0, 0);
		send(48'h9abc, 0, '1, 0, 1, 0);
		send(48'h5678, 1, 40'h1, 0, 0, 0);
		send(48'hdef0, 0, 40'h1, 0, 1, 0);
		drain_and_write(1);
		send(48'haaaa_aaaa_aaaa, 1, 40'haa_aaaa_aaaa, 0, 0, 0);
		send(48'h5555_5555_5555, 0, 40'h55_5555_5555, 1, 1, 0);
		send(48'h5555_5555_5555, 1, 40'h0, 0, 1, 0);

		sink_on = 1;
		foreach (lim[k]) begin
			drain_and_write(CfgW'(lim[k]));
			random_phase(300, k < 4 ? 6 : 16);
		end
		// long miss run without end of request
		drain_and_write(1);
		for (int i = 0; i < 100; i++)
			send({16'hc0de, 32'(i)}, i[0], 40'(i), 0, 0, 0);
		send(48'h1, 0, 40'h1, 0, 1, 0);
		hold_off = 1;
		random_phase(100, 16);
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (LINES + 10) @(posedge clk);
		$display("sent %0d requests over lines_in_use 0,1,2,3,64,127", sent);
		$display("hits %0d, evictions %0d, writebacks %0d", hit_count, evict_count,
			writeback_count);
		if (fail_count == 0)
			$display("farthest_next_use_cache: match");
		else
			$display("farthest_next_use_cache: mismatch");
		$finish;
	end
endmodule
